// ----- rtl/radix_page_table_engine_macros.svh -----
`ifndef RADIX_PAGE_TABLE_ENGINE_MACROS_SVH
`define RADIX_PAGE_TABLE_ENGINE_MACROS_SVH

// same-cycle implication, checked on i_clk, off while in reset
`define RPTE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("radix page table engine assertion failed");

// next-cycle implication, checked on i_clk, off while in reset
`define RPTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("radix page table engine assertion failed");

`endif

// ----- rtl/rpte_pkg.sv -----
package rpte_pkg;

    localparam int CFG_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CMD_W     = 3;
    localparam int VPN_W     = 16;
    localparam int MAP_W     = 17;

    localparam int MAX_LEVELS_DEF     = 4;
    localparam int MAX_INDEX_BITS_DEF = 4;
    localparam int NODE_COUNT_DEF     = 64;
    localparam int FRAME_BITS_DEF     = 20;

    localparam int LEVELS_RST = 2;
    localparam int IDXB_RST   = 4;

    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS  = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TRANSLATE  = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_LOOKUP     = 3'd2,
        CMD_SET_DIRTY  = 3'd3,
        CMD_SET_REF    = 3'd4,
        CMD_INVALIDATE = 3'd5,
        CMD_CLEAR      = 3'd6
    } t_cmd;

    typedef struct packed {
        logic [CFG_W-1:0] level_count;
        logic [CFG_W-1:0] index_bits;
    } t_cfg;

    typedef struct packed {
        logic status;
        logic referenced;
        logic dirty;
        logic hit;
    } t_flags;

endpackage

// ----- rtl/rpte_index.sv -----
module rpte_index #(
    parameter int MAX_INDEX_BITS = rpte_pkg::MAX_INDEX_BITS_DEF,
    parameter int NODE_COUNT     = rpte_pkg::NODE_COUNT_DEF,
    parameter int SHIFT_W        = 4
) (
    input  logic [rpte_pkg::VPN_W-1:0]                        i_vpn,
    input  logic [SHIFT_W-1:0]                                i_shift,
    input  logic [rpte_pkg::CFG_W-1:0]                        i_index_bits,
    input  logic [$clog2(NODE_COUNT)-1:0]                     i_node,
    output logic [$clog2(NODE_COUNT)+MAX_INDEX_BITS-1:0]      o_addr
);

    logic [rpte_pkg::VPN_W-1:0]  shifted;
    logic [MAX_INDEX_BITS-1:0]   mask;
    logic [MAX_INDEX_BITS-1:0]   idx;

    always_comb begin
        shifted = i_vpn >> i_shift;
        for (int i = 0; i < MAX_INDEX_BITS; i++) begin
            mask[i] = (rpte_pkg::CFG_W + 1)'(i) < {1'b0, i_index_bits};
        end
        idx    = shifted[MAX_INDEX_BITS-1:0] & mask;
        o_addr = {i_node, idx};
    end

endmodule

// ----- rtl/rpte_ctrl.sv -----
module rpte_ctrl #(
    parameter int MAX_INDEX_BITS = rpte_pkg::MAX_INDEX_BITS_DEF,
    parameter int NODE_COUNT     = rpte_pkg::NODE_COUNT_DEF,
    parameter int FRAME_BITS     = rpte_pkg::FRAME_BITS_DEF,
    parameter int SHIFT_W        = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rpte_pkg::t_cfg                 i_cfg,
    input  logic                           i_clr_req,
    output logic                           o_clr_ack,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [rpte_pkg::CMD_W-1:0]     i_cmd,
    input  logic [rpte_pkg::VPN_W-1:0]     i_vpn,
    input  logic [FRAME_BITS-1:0]          i_frame,
    input  logic                           i_flag,
    output logic                           o_res_valid,
    input  logic                           i_res_ready,
    output rpte_pkg::t_flags               o_res_flags,
    output logic [FRAME_BITS-1:0]          o_res_frame,
    output logic [rpte_pkg::MAP_W-1:0]     o_res_count
);

    localparam int SLOTS_W = MAX_INDEX_BITS;
    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int ADDR_W  = NODE_W + SLOTS_W;
    localparam int LEAF_W  = FRAME_BITS + 3;
    localparam int WORD_W  = (LEAF_W > NODE_W) ? LEAF_W : NODE_W;
    localparam int DEPTH   = NODE_COUNT * (2 ** SLOTS_W);

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_CHK,
        S_ZERO,
        S_LINK,
        S_DONE
    } t_state;

    t_state                         r_state;
    rpte_pkg::t_cmd                 r_cmd;
    logic [rpte_pkg::VPN_W-1:0]     r_vpn;
    logic [FRAME_BITS-1:0]          r_frame_in;
    logic                           r_flag;
    logic [rpte_pkg::CFG_W-1:0]     r_level;
    logic [SHIFT_W-1:0]             r_shift;
    logic [NODE_W-1:0]              r_node;
    logic [ADDR_W-1:0]              r_pos;
    logic [SLOTS_W-1:0]             r_sweep;
    logic [NODE_W:0]                r_next_free;
    logic [rpte_pkg::MAP_W-1:0]     r_count;
    logic                           r_reply;
    rpte_pkg::t_flags               r_flags;
    logic [FRAME_BITS-1:0]          r_frame;

    logic [WORD_W-1:0]              r_mem [DEPTH];
    logic [WORD_W-1:0]              r_rdata;

    logic [ADDR_W-1:0]              idx_addr;
    logic                           last;
    logic                           e_valid;
    logic                           e_dirty;
    logic                           e_ref;
    logic                           l_valid;
    logic                           l_dirty;
    logic                           l_ref;
    logic [FRAME_BITS-1:0]          l_frame;
    logic                           cnt_inc;
    logic                           cnt_dec;
    logic                           child_ok;
    logic [SHIFT_W-1:0]             shift_next;
    logic                           mem_we;
    logic [ADDR_W-1:0]              mem_addr;
    logic [WORD_W-1:0]              mem_wdata;

    rpte_index #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .NODE_COUNT     (NODE_COUNT),
        .SHIFT_W        (SHIFT_W)
    ) u_index (
        .i_vpn        (r_vpn),
        .i_shift      (r_shift),
        .i_index_bits (i_cfg.index_bits),
        .i_node       (r_node),
        .o_addr       (idx_addr)
    );

    always_comb begin
        last       = r_level == (i_cfg.level_count - rpte_pkg::CFG_W'(1));
        shift_next = r_shift - SHIFT_W'(i_cfg.index_bits);
        e_valid    = r_rdata[FRAME_BITS];
        e_dirty    = r_rdata[FRAME_BITS+1];
        e_ref      = r_rdata[FRAME_BITS+2];
        l_valid    = e_valid;
        l_dirty    = e_dirty;
        l_ref      = e_ref;
        l_frame    = r_rdata[FRAME_BITS-1:0];
        cnt_inc    = 1'b0;
        cnt_dec    = 1'b0;
        case (r_cmd)
            rpte_pkg::CMD_TRANSLATE: begin
                if (e_valid) l_ref = 1'b1;
            end
            rpte_pkg::CMD_INSERT: begin
                l_frame = r_frame_in;
                l_valid = 1'b1;
                l_ref   = 1'b1;
                cnt_inc = !e_valid;
            end
            rpte_pkg::CMD_SET_DIRTY: begin
                if (e_valid) l_dirty = r_flag;
            end
            rpte_pkg::CMD_SET_REF: begin
                if (e_valid) l_ref = r_flag;
            end
            rpte_pkg::CMD_INVALIDATE: begin
                if (e_valid) begin
                    l_valid = 1'b0;
                    cnt_dec = 1'b1;
                end
            end
            default: begin
            end
        endcase
        child_ok = (r_rdata != '0) && ({1'b0, r_rdata} < (WORD_W + 1)'(NODE_COUNT));
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_pos;
        mem_wdata = '0;
        case (r_state)
            S_CLR, S_ZERO: begin
                mem_we   = 1'b1;
                mem_addr = {r_node, r_sweep};
            end
            S_RD: begin
                mem_addr = idx_addr;
            end
            S_CHK: begin
                mem_we    = last;
                mem_wdata = WORD_W'({l_ref, l_dirty, l_valid, l_frame});
            end
            S_LINK: begin
                mem_we    = 1'b1;
                mem_wdata = WORD_W'(r_node);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    assign o_clr_ack   = (r_state == S_IDLE) && i_clr_req;
    assign o_in_ready  = (r_state == S_IDLE) && !i_clr_req;
    assign o_res_valid = r_state == S_DONE;
    assign o_res_flags = r_flags;
    assign o_res_frame = r_frame;
    assign o_res_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_node      <= '0;
            r_sweep     <= '0;
            r_next_free <= (NODE_W + 1)'(1);
            r_count     <= '0;
            r_reply     <= 1'b0;
        end else begin
            case (r_state)
                S_CLR: begin
                    r_sweep <= r_sweep + SLOTS_W'(1);
                    if (&r_sweep) begin
                        r_next_free <= (NODE_W + 1)'(1);
                        r_count     <= '0;
                        r_state     <= r_reply ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_clr_req) begin
                        r_node  <= '0;
                        r_sweep <= '0;
                        r_reply <= 1'b0;
                        r_state <= S_CLR;
                    end else if (i_in_valid) begin
                        r_cmd      <= rpte_pkg::t_cmd'(i_cmd);
                        r_vpn      <= i_vpn;
                        r_frame_in <= i_frame;
                        r_flag     <= i_flag;
                        r_level    <= '0;
                        r_node     <= '0;
                        r_sweep    <= '0;
                        r_shift    <= SHIFT_W'(
                            {3'b000, i_cfg.level_count - rpte_pkg::CFG_W'(1)}
                            * {3'b000, i_cfg.index_bits});
                        r_flags    <= '0;
                        r_frame    <= '0;
                        case (rpte_pkg::t_cmd'(i_cmd))
                            rpte_pkg::CMD_CLEAR: begin
                                r_reply <= 1'b1;
                                r_state <= S_CLR;
                            end
                            rpte_pkg::CMD_TRANSLATE, rpte_pkg::CMD_INSERT,
                            rpte_pkg::CMD_LOOKUP, rpte_pkg::CMD_SET_DIRTY,
                            rpte_pkg::CMD_SET_REF, rpte_pkg::CMD_INVALIDATE: begin
                                r_state <= S_RD;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_RD: begin
                    r_pos   <= idx_addr;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (last) begin
                        r_flags.hit        <= l_valid;
                        r_flags.dirty      <= l_dirty;
                        r_flags.referenced <= l_ref;
                        r_frame            <= l_frame;
                        if (cnt_inc) begin
                            r_count <= r_count + rpte_pkg::MAP_W'(1);
                        end else if (cnt_dec) begin
                            r_count <= r_count - rpte_pkg::MAP_W'(1);
                        end
                        r_state <= S_DONE;
                    end else if (child_ok) begin
                        r_node  <= r_rdata[NODE_W-1:0];
                        r_level <= r_level + rpte_pkg::CFG_W'(1);
                        r_shift <= shift_next;
                        r_state <= S_RD;
                    end else if (r_cmd != rpte_pkg::CMD_INSERT) begin
                        r_state <= S_DONE;
                    end else if (r_next_free >= (NODE_W + 1)'(NODE_COUNT)) begin
                        r_flags.status <= 1'b1;
                        r_state        <= S_DONE;
                    end else begin
                        r_node      <= r_next_free[NODE_W-1:0];
                        r_next_free <= r_next_free + (NODE_W + 1)'(1);
                        r_sweep     <= '0;
                        r_state     <= S_ZERO;
                    end
                end
                S_ZERO: begin
                    r_sweep <= r_sweep + SLOTS_W'(1);
                    if (&r_sweep) begin
                        r_state <= S_LINK;
                    end
                end
                S_LINK: begin
                    r_level <= r_level + rpte_pkg::CFG_W'(1);
                    r_shift <= shift_next;
                    r_state <= S_RD;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- rtl/radix_page_table_engine.sv -----
// Channel   Direction  Handshake                     Payload
// s_axis    in         s_axis_tvalid/s_axis_tready   command, page, frame, flag
// m_axis    out        m_axis_tvalid/m_axis_tready   hit, frame, dirty, ref, count, status
// cfg       in         i_cfg_valid/o_cfg_ready       register index, write data
//
// Each level walked takes a table read, then a check, on the single table port, and
// the result is then offered; each node allocated by insert is zeroed and then linked.
// Clear sweeps the root node and then offers its result.
// After reset, and after each write to the level-count or index-bits register, the root
// node is swept while s_axis_tready stays low.
// A finished result waits in the output register while the next command is taken.
`include "radix_page_table_engine_macros.svh"

module radix_page_table_engine #(
    parameter int MAX_LEVELS     = rpte_pkg::MAX_LEVELS_DEF,
    parameter int MAX_INDEX_BITS = rpte_pkg::MAX_INDEX_BITS_DEF,
    parameter int NODE_COUNT     = rpte_pkg::NODE_COUNT_DEF,
    parameter int FRAME_BITS     = rpte_pkg::FRAME_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // page_number, frame_in, flag_value
    input  logic [((FRAME_BITS + 24) / 8) * 8-1:0]  s_axis_tdata,
    // command
    input  logic [rpte_pkg::CMD_W-1:0]              s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    // hit, frame_out, dirty_out, referenced_out, mapped_count
    output logic [((FRAME_BITS + 27) / 8) * 8-1:0]  m_axis_tdata,
    // status
    output logic                                    m_axis_tuser,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [rpte_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [rpte_pkg::CFG_W-1:0]              i_cfg_data
);

    localparam int OUT_W     = ((FRAME_BITS + 27) / 8) * 8;
    localparam int SHIFT_MAX = (MAX_LEVELS - 1) * MAX_INDEX_BITS;
    localparam int SHIFT_W   = (SHIFT_MAX < 1) ? 1 : $clog2(SHIFT_MAX + 1);
    localparam int LVL_RST   = (rpte_pkg::LEVELS_RST > MAX_LEVELS) ?
                               MAX_LEVELS : rpte_pkg::LEVELS_RST;
    localparam int IDX_RST   = (rpte_pkg::IDXB_RST > MAX_INDEX_BITS) ?
                               MAX_INDEX_BITS : rpte_pkg::IDXB_RST;

    rpte_pkg::t_cfg                  r_cfg;
    logic                            r_clr_req;
    logic                            r_out_valid;
    rpte_pkg::t_flags                r_out_flags;
    logic [FRAME_BITS-1:0]           r_out_frame;
    logic [rpte_pkg::MAP_W-1:0]      r_out_count;

    logic [rpte_pkg::CFG_W-1:0]      n_sat_lc;
    logic [rpte_pkg::CFG_W-1:0]      n_sat_ib;
    logic                            cfg_wr;
    logic                            clr_ack;
    logic                            res_valid;
    logic                            res_ready;
    rpte_pkg::t_flags                res_flags;
    logic [FRAME_BITS-1:0]           res_frame;
    logic [rpte_pkg::MAP_W-1:0]      res_count;
    logic                            cfg_clr_wr;
    logic                            out_clean;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_comb begin
        n_sat_lc = i_cfg_data;
        n_sat_ib = i_cfg_data;
        if (i_cfg_data == '0) begin
            n_sat_lc = rpte_pkg::CFG_W'(1);
            n_sat_ib = rpte_pkg::CFG_W'(1);
        end
        if ({1'b0, i_cfg_data} > (rpte_pkg::CFG_W + 1)'(MAX_LEVELS)) begin
            n_sat_lc = rpte_pkg::CFG_W'(MAX_LEVELS);
        end
        if ({1'b0, i_cfg_data} > (rpte_pkg::CFG_W + 1)'(MAX_INDEX_BITS)) begin
            n_sat_ib = rpte_pkg::CFG_W'(MAX_INDEX_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_count <= rpte_pkg::CFG_W'(LVL_RST);
            r_cfg.index_bits  <= rpte_pkg::CFG_W'(IDX_RST);
            r_clr_req         <= 1'b0;
        end else begin
            if (clr_ack) begin
                r_clr_req <= 1'b0;
            end
            if (cfg_wr) begin
                case (i_cfg_index)
                    rpte_pkg::REG_LEVEL_COUNT: begin
                        r_cfg.level_count <= n_sat_lc;
                        r_clr_req         <= 1'b1;
                    end
                    rpte_pkg::REG_INDEX_BITS: begin
                        r_cfg.index_bits <= n_sat_ib;
                        r_clr_req        <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    rpte_ctrl #(
        .MAX_INDEX_BITS (MAX_INDEX_BITS),
        .NODE_COUNT     (NODE_COUNT),
        .FRAME_BITS     (FRAME_BITS),
        .SHIFT_W        (SHIFT_W)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_clr_req   (r_clr_req),
        .o_clr_ack   (clr_ack),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_cmd       (s_axis_tuser),
        .i_vpn       (s_axis_tdata[rpte_pkg::VPN_W-1:0]),
        .i_frame     (s_axis_tdata[rpte_pkg::VPN_W +: FRAME_BITS]),
        .i_flag      (s_axis_tdata[rpte_pkg::VPN_W + FRAME_BITS]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res_flags (res_flags),
        .o_res_frame (res_frame),
        .o_res_count (res_count)
    );

    assign res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_flags <= res_flags;
            r_out_frame <= res_frame;
            r_out_count <= res_count;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_flags.status;
    assign m_axis_tdata  = OUT_W'({r_out_count, r_out_flags.referenced, r_out_flags.dirty,
                                   r_out_frame, r_out_flags.hit});

    assign cfg_clr_wr = cfg_wr && (i_cfg_index == rpte_pkg::REG_LEVEL_COUNT ||
                                   i_cfg_index == rpte_pkg::REG_INDEX_BITS);
    assign out_clean  = !r_out_flags.hit && r_out_frame == '0;

    `RPTE_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RPTE_ASSERT_IMP(a_exhaust_no_hit, r_out_valid && r_out_flags.status, out_clean)
    `RPTE_ASSERT_NEXT(a_cfg_forces_clear, cfg_clr_wr, !s_axis_tready)

endmodule
